FILE: sv/pie_pkg.sv
package pie_pkg;

	localparam int unsigned OUT_WIDTH = 32;
	localparam int unsigned STATUS_WIDTH = 3;

	localparam logic [STATUS_WIDTH-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_UNDER = 3'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_DIVZ  = 3'd2;
	localparam logic [STATUS_WIDTH-1:0] ST_OVER  = 3'd3;
	localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_PCT   = 8'h25;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_MOD  = 3'd5
	} op_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_req;
	} char_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0]  value;
		logic [STATUS_WIDTH-1:0]      status;
	} res_t;

	typedef struct packed {
		logic                    num_start;
		logic                    num_neg;
		logic                    num_digit;
		logic                    push_num;
		logic                    read_ops;
		logic                    start_iter;
		logic                    iter_step;
		logic                    write_res;
		logic                    clear_stack;
		logic                    load_out;
		op_t                     op;
		logic [STATUS_WIDTH-1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic lt2;
		logic empty;
		logic b_zero;
		logic iter_done;
	} sts_t;

endpackage

FILE: sv/pie_dp.sv
module pie_dp #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      ch,
	input  pie_pkg::cmd_t   cmd,
	output pie_pkg::sts_t   sts,
	output pie_pkg::res_t   res_data
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned IW = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned OW = pie_pkg::OUT_WIDTH;

	logic [W-1:0]  stack_mem [STACK_DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [W-1:0]  accum_q;
	logic          neg_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic          na_q;
	logic          nb_q;
	logic [IW-1:0] it_cnt_q;
	logic [W-1:0]  digit;
	logic [W-1:0]  accum_next;
	logic [W-1:0]  push_val;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;
	logic [W:0]    rem_sh;
	logic [W:0]    trial;
	logic [W-1:0]  res_val;
	logic [OW-1:0] top_ext;
	logic signed [OW-1:0]           value_q;
	logic [pie_pkg::STATUS_WIDTH-1:0] status_q;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);

	assign digit      = {{(W-4){1'b0}}, ch[3:0]};
	assign accum_next = (accum_q << 3) + (accum_q << 1) + digit;
	assign push_val   = neg_q ? (W'(0) - accum_q) : accum_q;

	assign mag_a = a_q[W-1] ? (W'(0) - a_q) : a_q;
	assign mag_b = b_q[W-1] ? (W'(0) - b_q) : b_q;

	assign rem_sh = {acc_q, y_q[W-1]};
	assign trial  = rem_sh - {1'b0, x_q};

	always_comb begin
		case (cmd.op)
			pie_pkg::OP_ADD: res_val = a_q + b_q;
			pie_pkg::OP_SUB: res_val = a_q - b_q;
			pie_pkg::OP_MUL: res_val = acc_q;
			pie_pkg::OP_DIV: res_val = (na_q ^ nb_q) ? (W'(0) - y_q) : y_q;
			pie_pkg::OP_MOD: res_val = na_q ? (W'(0) - acc_q) : acc_q;
			default:         res_val = a_q;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < OW; gi++) begin : g_ext
			if (gi < W) begin : g_in
				assign top_ext[gi] = b_q[gi];
			end else begin : g_sign
				assign top_ext[gi] = b_q[W-1];
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.push_num) begin
			stack_mem[count_q[AW-1:0]] <= push_val;
		end else if (cmd.write_res) begin
			stack_mem[cnt_m2[AW-1:0]] <= res_val;
		end
		if (cmd.read_ops) begin
			a_q <= stack_mem[cnt_m2[AW-1:0]];
			b_q <= stack_mem[cnt_m1[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			it_cnt_q <= '0;
		end else begin
			if (cmd.clear_stack) begin
				count_q <= '0;
			end else if (cmd.push_num) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.write_res) begin
				count_q <= cnt_m1;
			end
			if (cmd.start_iter) begin
				it_cnt_q <= IW'(VALUE_WIDTH);
			end else if (cmd.iter_step) begin
				it_cnt_q <= it_cnt_q - IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.num_start) begin
			accum_q <= digit;
			neg_q   <= cmd.num_neg;
		end else if (cmd.num_digit) begin
			accum_q <= accum_next;
		end
		if (cmd.start_iter) begin
			na_q  <= a_q[W-1];
			nb_q  <= b_q[W-1];
			acc_q <= '0;
			if (cmd.op == pie_pkg::OP_MUL) begin
				x_q <= a_q;
				y_q <= b_q;
			end else begin
				x_q <= mag_b;
				y_q <= mag_a;
			end
		end else if (cmd.iter_step) begin
			if (cmd.op == pie_pkg::OP_MUL) begin
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= x_q << 1;
				y_q <= y_q >> 1;
			end else begin
				if (!trial[W]) begin
					acc_q <= trial[W-1:0];
					y_q   <= {y_q[W-2:0], 1'b1};
				end else begin
					acc_q <= rem_sh[W-1:0];
					y_q   <= {y_q[W-2:0], 1'b0};
				end
			end
		end
		if (cmd.load_out) begin
			status_q <= cmd.out_status;
			value_q  <= (cmd.out_status == pie_pkg::ST_OK) ? top_ext : '0;
		end
	end

	assign sts.full      = (count_q == CW'(STACK_DEPTH));
	assign sts.lt2       = (count_q < CW'(2));
	assign sts.empty     = (count_q == '0);
	assign sts.b_zero    = (b_q == '0);
	assign sts.iter_done = (it_cnt_q == '0);

	assign res_data.value  = value_q;
	assign res_data.status = status_q;

endmodule

FILE: sv/pie_ctrl.sv
module pie_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_stall,
	input  pie_pkg::char_t  char_data,
	output logic            res_valid,
	input  logic            res_stall,
	output pie_pkg::cmd_t   cmd,
	input  pie_pkg::sts_t   sts
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_PUSH   = 7'b0000010,
		S_OPRD   = 7'b0000100,
		S_OPEX   = 7'b0001000,
		S_OPITER = 7'b0010000,
		S_EMRD   = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t        state_q;
	state_t        state_d;
	pie_pkg::op_t  cur_op_q;
	pie_pkg::op_t  op2_q;
	pie_pkg::op_t  op_in;
	logic          end_q;
	logic          in_number_q;
	logic          pending_q;
	logic          res_valid_q;
	logic [pie_pkg::STATUS_WIDTH-1:0] err_q;
	logic [pie_pkg::STATUS_WIDTH-1:0] err_code;
	logic          err_set;
	logic          step_done;
	logic          accept;
	logic          is_digit;

	assign accept   = (state_q == S_IDLE) && char_valid;
	assign is_digit = !char_data.end_req && (char_data.ch >= pie_pkg::CH_ZERO) &&
		(char_data.ch <= pie_pkg::CH_NINE);

	always_comb begin
		op_in = pie_pkg::OP_NONE;
		if (!char_data.end_req) begin
			unique case (char_data.ch)
				pie_pkg::CH_PLUS:  op_in = pie_pkg::OP_ADD;
				pie_pkg::CH_STAR:  op_in = pie_pkg::OP_MUL;
				pie_pkg::CH_SLASH: op_in = pie_pkg::OP_DIV;
				pie_pkg::CH_PCT:   op_in = pie_pkg::OP_MOD;
				default:           op_in = pie_pkg::OP_NONE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.op         = cur_op_q;
		cmd.num_neg    = pending_q;
		cmd.out_status = (err_q != pie_pkg::ST_OK) ? err_q :
			(sts.empty ? pie_pkg::ST_EMPTY : pie_pkg::ST_OK);
		state_d   = state_q;
		step_done = 1'b0;
		err_set   = 1'b0;
		err_code  = pie_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (char_valid) begin
					if (is_digit) begin
						cmd.num_start = !in_number_q;
						cmd.num_digit = in_number_q;
					end else if (in_number_q) begin
						state_d = S_PUSH;
					end else if (pending_q || (op_in != pie_pkg::OP_NONE)) begin
						state_d = S_OPRD;
					end else if (char_data.end_req) begin
						state_d = S_EMRD;
					end
				end
			end
			S_PUSH: begin
				if (!sts.full) begin
					cmd.push_num = 1'b1;
				end else begin
					err_set  = 1'b1;
					err_code = pie_pkg::ST_OVER;
				end
				step_done = 1'b1;
			end
			S_OPRD: begin
				if (sts.lt2) begin
					err_set   = 1'b1;
					err_code  = pie_pkg::ST_UNDER;
					step_done = 1'b1;
				end else begin
					cmd.read_ops = 1'b1;
					state_d      = S_OPEX;
				end
			end
			S_OPEX: begin
				if ((cur_op_q == pie_pkg::OP_ADD) || (cur_op_q == pie_pkg::OP_SUB)) begin
					cmd.write_res = 1'b1;
					step_done     = 1'b1;
				end else if ((cur_op_q != pie_pkg::OP_MUL) && sts.b_zero) begin
					err_set   = 1'b1;
					err_code  = pie_pkg::ST_DIVZ;
					step_done = 1'b1;
				end else begin
					cmd.start_iter = 1'b1;
					state_d        = S_OPITER;
				end
			end
			S_OPITER: begin
				if (sts.iter_done) begin
					cmd.write_res = 1'b1;
					step_done     = 1'b1;
				end else begin
					cmd.iter_step = 1'b1;
				end
			end
			S_EMRD: begin
				cmd.read_ops = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (!res_valid_q || !res_stall) begin
					cmd.load_out    = 1'b1;
					cmd.clear_stack = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (step_done) begin
			if (op2_q != pie_pkg::OP_NONE) begin
				state_d = S_OPRD;
			end else if (end_q) begin
				state_d = S_EMRD;
			end else begin
				state_d = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_op_q    <= pie_pkg::OP_NONE;
			op2_q       <= pie_pkg::OP_NONE;
			end_q       <= 1'b0;
			in_number_q <= 1'b0;
			pending_q   <= 1'b0;
			err_q       <= pie_pkg::ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				end_q <= char_data.end_req;
				if (is_digit) begin
					in_number_q <= 1'b1;
					if (!in_number_q) begin
						pending_q <= 1'b0;
					end
				end else begin
					in_number_q <= 1'b0;
					pending_q   <= !char_data.end_req && (char_data.ch == pie_pkg::CH_MINUS);
					if (in_number_q) begin
						op2_q <= op_in;
					end else if (pending_q) begin
						cur_op_q <= pie_pkg::OP_SUB;
						op2_q    <= op_in;
					end else begin
						cur_op_q <= op_in;
						op2_q    <= pie_pkg::OP_NONE;
					end
				end
			end
			if (step_done && (op2_q != pie_pkg::OP_NONE)) begin
				cur_op_q <= op2_q;
				op2_q    <= pie_pkg::OP_NONE;
			end
			if (err_set && (err_q == pie_pkg::ST_OK)) begin
				err_q <= err_code;
			end
			if (cmd.load_out) begin
				err_q       <= pie_pkg::ST_OK;
				in_number_q <= 1'b0;
				pending_q   <= 1'b0;
				end_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign char_stall = (state_q != S_IDLE);
	assign res_valid  = res_valid_q;

endmodule

FILE: sv/postfix_integer_evaluator.sv
// Postfix integer evaluator. Characters of a space-separated postfix expression
// enter on the char channel (char_valid, char_stall, char_data), one request each.
// A request with end_req set closes the expression; one result then leaves on the
// res channel (res_valid, res_stall, res_data) with the top of the stack and a status.
// Digits and ignored characters are taken in the idle state. A character that ends
// a number adds a push step, and an add or subtract adds a stack read step and an
// execute and write-back step. Multiply, divide and remainder run on a shared
// shift-and-add or restoring unit, one bit per cycle, before their write-back.
// An operator that ends a number or follows a pending subtraction runs both steps
// back to back. An end request, after any pending step, reads the stack and then
// registers its result on the output once the output holds no stalled result.
// The input is stalled while a character is being worked on; a result waiting on a
// stalled receiver does not block further characters, only the next end request.
// Reset empties the stack, clears the number in progress and the latched error,
// and leaves the output channel empty.
module postfix_integer_evaluator #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_stall,
	input  pie_pkg::char_t  char_data,
	output logic            res_valid,
	input  logic            res_stall,
	output pie_pkg::res_t   res_data
);

	pie_pkg::cmd_t cmd;
	pie_pkg::sts_t sts;

	pie_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	pie_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (char_data.ch),
		.cmd      (cmd),
		.sts      (sts),
		.res_data (res_data)
	);

endmodule

FILE: sv/pie_checker.sv
module pie_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            char_valid,
	input logic            char_stall,
	input pie_pkg::char_t  char_data,
	input logic            res_valid,
	input logic            res_stall,
	input pie_pkg::res_t   res_data
);

	logic [1:0] outstanding_q;
	logic       end_acc;
	logic       res_acc;

	assign end_acc = char_valid && !char_stall && char_data.end_req;
	assign res_acc = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (end_acc && !res_acc) begin
			outstanding_q <= outstanding_q + 2'd1;
		end else if (res_acc && !end_acc) begin
			outstanding_q <= outstanding_q - 2'd1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("result changed while stalled");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (outstanding_q != 2'd0))
		else $error("result without an end request");

	a_error_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status != pie_pkg::ST_OK) |-> (res_data.value == '0))
		else $error("non-zero value with a failing status");

endmodule

bind postfix_integer_evaluator pie_checker u_pie_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.char_data  (char_data),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_data   (res_data)
);
